// ===== rtl/core/averaged_change_reporter_macros.svh =====
// assertion macros shared by the averaged change reporter rtl
`ifndef AVERAGED_CHANGE_REPORTER_MACROS_SVH
`define AVERAGED_CHANGE_REPORTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ACR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ACR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/acr_pkg.sv =====
// constants, register codes and state type of the averaged change reporter
package acr_pkg;

  // ring depth and derived widths
  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DATA_W      = 12;
  localparam int SUM_W       = DATA_W + ADDR_W;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int SC_W        = 7;
  localparam int CMP_W       = (CNT_W > SC_W) ? CNT_W : SC_W;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SENSITIVITY    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_LOW      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_AVERAGE = 3'd4;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } st_t;

endpackage

// ===== rtl/core/averaged_change_reporter.sv =====
// averaged change reporter: moving average ring with deadband publishing
//
//  channel | direction | handshake         | contents
//  in_     | input     | tvalid/tready     | tdata: distance[11:0], force_publish[12]
//  out_    | output    | tvalid/tready     | tdata: reported_value, average; tuser: publish
//  cfg_    | input     | we, no wait       | addr selects register, wdata value
//
// An item normally passes a read of the displaced ring entry, an update and
// write-back, 18 steps of the bit-serial divider and a final state that
// forms the result. After sample_count is written, the next item sweeps the
// ring once to rebuild the sum over the effective ring length (sample_count
// held to 1..64).
// Reset (rst_n low, synchronous) clears control state and the ring valid bits,
// so the ring reads as zeros at once. One item is in work at a time; a new
// word is taken while a finished result still waits in the output register.
module averaged_change_reporter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] distance, [12] force_publish, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] reported_value, [23:12] average
  output logic [0:0]  out_tuser,  // [0] publish
  input  logic                           cfg_we,
  input  logic [acr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [acr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAX_SAMPLES = acr_pkg::MAX_SAMPLES;
  localparam int ADDR_W      = acr_pkg::ADDR_W;
  localparam int CNT_W       = acr_pkg::CNT_W;
  localparam int DATA_W      = acr_pkg::DATA_W;
  localparam int SUM_W       = acr_pkg::SUM_W;
  localparam int DIV_CNT_W   = acr_pkg::DIV_CNT_W;
  localparam int SC_W        = acr_pkg::SC_W;
  localparam int CMP_W       = acr_pkg::CMP_W;

  // configuration registers
  logic [SC_W-1:0]   sample_count_r;
  logic [DATA_W-1:0] sensitivity_r;
  logic [DATA_W-1:0] limit_low_r;
  logic [DATA_W-1:0] limit_high_r;
  logic              report_average_r;
  logic              stale_r;

  // sequencer and item state
  acr_pkg::st_t      state_r;
  logic [DATA_W-1:0] dist_r;
  logic              force_r;
  logic [ADDR_W-1:0] wp_r;
  logic [ADDR_W-1:0] write_pointer_r;
  logic [CNT_W-1:0]  fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] last_rep_r;
  logic [CNT_W-1:0]  sw_cnt_r;
  logic              pend_r;

  // divider
  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // ring memory and valid bits
  logic [DATA_W-1:0]      ring_mem [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] valid_r;
  logic [DATA_W-1:0]      rd_data_r;
  logic                   rd_vld_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   mem_we;

  // output register
  logic              out_valid_r;
  logic              out_pub_r;
  logic [DATA_W-1:0] out_val_r;
  logic [DATA_W-1:0] out_avg_r;

  // combinational helpers
  logic [CNT_W-1:0]  n_eff;
  logic [CMP_W-1:0]  sc_ext;
  logic [ADDR_W-1:0] wp_start;
  logic [CNT_W-1:0]  wp_inc;
  logic [DATA_W-1:0] rd_word;
  logic [SUM_W-1:0]  sum_inc;
  logic [SUM_W-1:0]  sum_sweep;
  logic [CNT_W:0]    trial;
  logic              trial_ge;
  logic [DATA_W-1:0] avg;
  logic [DATA_W-1:0] test_val;
  logic [DATA_W:0]   band_hi;
  logic [DATA_W:0]   val_plus;
  logic              in_band;
  logic              pub_raw;
  logic              filling;
  logic              pub;
  logic              out_free;
  logic              in_acc;

  // effective ring length
  always_comb begin
    sc_ext = CMP_W'(sample_count_r);
    if (sample_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (sc_ext > CMP_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = CNT_W'(sc_ext);
    end
  end

  assign in_tready = (state_r == acr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wp_start  = (CNT_W'(write_pointer_r) < n_eff) ? write_pointer_r : '0;
  assign wp_inc    = CNT_W'(wp_r) + CNT_W'(1);

  // ring read data, unwritten entries read as zero
  assign rd_word   = rd_vld_r ? rd_data_r : '0;
  assign sum_inc   = (sum_r - SUM_W'(rd_word)) + SUM_W'(dist_r);
  assign sum_sweep = sum_r + (pend_r ? SUM_W'(rd_word) : '0);
  assign rd_addr   = (state_r == acr_pkg::ST_SWEEP) ? sw_cnt_r[ADDR_W-1:0] : wp_r;
  assign mem_we    = (state_r == acr_pkg::ST_UPD);

  // divider trial subtract
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= (CNT_W+1)'(n_eff));

  // publish decision
  assign avg      = quo_r[DATA_W-1:0];
  assign test_val = report_average_r ? avg : dist_r;
  assign band_hi  = {1'b0, last_rep_r} + {1'b0, sensitivity_r};
  assign val_plus = {1'b0, test_val} + {1'b0, sensitivity_r};
  assign in_band  = (val_plus >= {1'b0, last_rep_r}) && ({1'b0, test_val} <= band_hi);
  assign pub_raw  = force_r ||
                    (!in_band && (test_val >= limit_low_r) && (test_val <= limit_high_r));
  assign filling  = (fill_r < n_eff);
  assign pub      = pub_raw && !filling;
  assign out_free = !out_valid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r   <= SC_W'(5);
      sensitivity_r    <= DATA_W'(2);
      limit_low_r      <= '0;
      limit_high_r     <= '1;
      report_average_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acr_pkg::REG_SAMPLE_COUNT:   sample_count_r   <= cfg_wdata[SC_W-1:0];
        acr_pkg::REG_SENSITIVITY:    sensitivity_r    <= cfg_wdata[DATA_W-1:0];
        acr_pkg::REG_LIMIT_LOW:      limit_low_r      <= cfg_wdata[DATA_W-1:0];
        acr_pkg::REG_LIMIT_HIGH:     limit_high_r     <= cfg_wdata[DATA_W-1:0];
        acr_pkg::REG_REPORT_AVERAGE: report_average_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wp_r] <= dist_r;
    end
    rd_data_r <= ring_mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[wp_r] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= acr_pkg::ST_IDLE;
      write_pointer_r <= '0;
      fill_r          <= '0;
      sum_r           <= '0;
      last_rep_r      <= '0;
      stale_r         <= 1'b0;
      pend_r          <= 1'b0;
      sw_cnt_r        <= '0;
      div_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && (cfg_addr == acr_pkg::REG_SAMPLE_COUNT)) begin
        stale_r <= 1'b1;
      end
      unique case (state_r)
        acr_pkg::ST_IDLE: begin
          if (in_acc) begin
            state_r <= acr_pkg::ST_RD;
          end
        end
        acr_pkg::ST_RD: begin
          state_r <= acr_pkg::ST_UPD;
        end
        acr_pkg::ST_UPD: begin
          write_pointer_r <= (wp_inc >= n_eff) ? '0 : wp_inc[ADDR_W-1:0];
          div_cnt_r       <= '0;
          if (stale_r) begin
            sum_r    <= '0;
            sw_cnt_r <= '0;
            pend_r   <= 1'b0;
            state_r  <= acr_pkg::ST_SWEEP;
          end else begin
            sum_r   <= sum_inc;
            state_r <= acr_pkg::ST_DIV;
          end
        end
        acr_pkg::ST_SWEEP: begin
          sum_r <= sum_sweep;
          if (sw_cnt_r < n_eff) begin
            sw_cnt_r <= sw_cnt_r + CNT_W'(1);
            pend_r   <= 1'b1;
          end else begin
            pend_r  <= 1'b0;
            stale_r <= 1'b0;
            state_r <= acr_pkg::ST_DIV;
          end
        end
        acr_pkg::ST_DIV: begin
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
            state_r <= acr_pkg::ST_DONE;
          end
        end
        acr_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (filling) begin
              fill_r <= fill_r + CNT_W'(1);
            end
            if (pub) begin
              last_rep_r <= test_val;
            end
            state_r <= acr_pkg::ST_IDLE;
          end
        end
        default: state_r <= acr_pkg::ST_IDLE;
      endcase
    end
  end

  // item capture, divider datapath and output words
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dist_r  <= in_tdata[DATA_W-1:0];
      force_r <= in_tdata[DATA_W];
      wp_r    <= wp_start;
    end
    if ((state_r == acr_pkg::ST_UPD) && !stale_r) begin
      quo_r <= sum_inc;
      rem_r <= '0;
    end else if ((state_r == acr_pkg::ST_SWEEP) && !(sw_cnt_r < n_eff)) begin
      quo_r <= sum_sweep;
      rem_r <= '0;
    end else if (state_r == acr_pkg::ST_DIV) begin
      rem_r <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(n_eff)) : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
    end
    if ((state_r == acr_pkg::ST_DONE) && out_free) begin
      out_pub_r <= pub;
      out_val_r <= pub ? test_val : '0;
      out_avg_r <= avg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_avg_r, out_val_r};
  assign out_tuser  = out_pub_r;

  // checks
  `include "averaged_change_reporter_macros.svh"

  `ACR_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_acc, state_r == acr_pkg::ST_RD, "accepted word did not start the read")
  `ACR_ASSERT_NOW(a_quiet_value, clk, rst_n, out_valid_r && !out_pub_r, out_val_r == '0, "reported value nonzero without publish")
  `ACR_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_r == acr_pkg::ST_DONE) && out_free, out_valid_r && (state_r == acr_pkg::ST_IDLE), "finished result not loaded")
  `ACR_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(MAX_SAMPLES), "fill count beyond ring depth")
  `ACR_ASSERT_NOW(a_sweep_end, clk, rst_n, state_r == acr_pkg::ST_SWEEP, sw_cnt_r <= n_eff, "sweep ran past the ring length")

endmodule
